>>> sv/ulbp_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the uniform-pattern rank table of the LBP labeler.
package ulbp_pkg;

  localparam int MAX_WIDTH      = 1024;
  localparam int NEIGHBOUR_BITS = 8;
  localparam int CODE_COUNT     = 1 << NEIGHBOUR_BITS;
  localparam int MIN_DIM        = 3;

  localparam int PIXEL_W     = 8;
  localparam int LABEL_W     = 10;
  localparam int ROW_W       = 16;
  localparam int OUT_COL_W   = 10;
  localparam int CFG_WIDTH_W = 11;
  localparam int CFG_LIMIT_W = 4;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 2;

  localparam int IMAGE_WIDTH_RESET  = 640;
  localparam int IMAGE_HEIGHT_RESET = 480;
  localparam int LIMIT_RESET        = 2;

  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_UNIFORM_LIMIT = 2'd2;

  // Transition counts are always even, so limits fall into five classes:
  // at most 0, 2, 4, 6 or 8 transitions.
  localparam int LIMIT_CLASSES = 5;
  localparam int CLASS_W       = 3;
  localparam int RANK_W        = 9;

  localparam int QUEUE_DEPTH = 4;
  localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);

  // Result slots of one pixel, in emission order.
  localparam int SLOT_COUNT = 4;

  typedef logic signed [LABEL_W-1:0] label_t;
  typedef logic [RANK_W-1:0]         rank_t;
  typedef rank_t [LIMIT_CLASSES-1:0] rank_set_t;
  typedef rank_set_t [CODE_COUNT-1:0] rank_rom_t;
  typedef logic [CLASS_W-1:0]        class_t;
  typedef logic [SLOT_COUNT-1:0]     slot_mask_t;

  localparam label_t BORDER_LABEL = label_t'(-1);

  localparam slot_mask_t SLOT_CENTER    = 4'b0001;
  localparam slot_mask_t SLOT_EDGE      = 4'b0010;
  localparam slot_mask_t SLOT_BOTTOM    = 4'b0100;
  localparam slot_mask_t SLOT_BOT_EDGE  = 4'b1000;

  // One queued pixel: its code and the results it still has to produce.
  typedef struct packed {
    logic [NEIGHBOUR_BITS-1:0] code;
    logic                      interior;
    slot_mask_t                mask;
    logic [ROW_W-1:0]          row_up;
    logic [ROW_W-1:0]          row;
    logic [OUT_COL_W-1:0]      col_left;
    logic [OUT_COL_W-1:0]      col_last;
  } desc_t;

  function automatic rank_rom_t build_rank_rom();
    rank_rom_t rom;
    int rank;
    int trans;
    logic [NEIGHBOUR_BITS-1:0] c;
    logic [NEIGHBOUR_BITS-1:0] diff;
    for (int k = 0; k < LIMIT_CLASSES; k++) begin
      rank = 1;
      for (int code = 0; code < CODE_COUNT; code++) begin
        c = NEIGHBOUR_BITS'(code);
        diff = {c[NEIGHBOUR_BITS-2:0], c[NEIGHBOUR_BITS-1]} ^ c;
        trans = $countones(diff);
        if (trans <= 2 * k) begin
          rom[code][k] = RANK_W'(rank);
          rank++;
        end else begin
          rom[code][k] = '0;
        end
      end
    end
    return rom;
  endfunction

  localparam rank_rom_t RANK_ROM = build_rank_rom();

  function automatic class_t limit_class(input logic [CFG_LIMIT_W-1:0] limit);
    class_t cls;
    if (limit >= CFG_LIMIT_W'(2 * (LIMIT_CLASSES - 1))) begin
      cls = CLASS_W'(LIMIT_CLASSES - 1);
    end else begin
      cls = CLASS_W'(limit >> 1);
    end
    return cls;
  endfunction

endpackage

>>> sv/ulbp_if.sv
`timescale 1ns / 1ps
// Valid/ready stream interfaces for pixels in and labels out.
interface ulbp_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_value;

  modport source (output valid, output pixel_value, input ready);
  modport sink (input valid, input pixel_value, output ready);
endinterface

interface ulbp_result_if;
  logic              valid;
  logic              ready;
  logic signed [9:0] label;
  logic [15:0]       out_row;
  logic [9:0]        out_col;
  logic              last;

  modport source (output valid, output label, output out_row, output out_col, output last,
                  input ready);
  modport sink (input valid, input label, input out_row, input out_col, input last,
                output ready);
endinterface

>>> sv/ulbp_front.sv
`timescale 1ns / 1ps
// Front end: raster counters, line memory, 3x3 window and LBP code generation.
module ulbp_front #(
  parameter int MAX_WIDTH = ulbp_pkg::MAX_WIDTH,
  localparam int COL_W  = $clog2(MAX_WIDTH),
  localparam int WCNT_W = $clog2(MAX_WIDTH + 1)
) (
  input  logic                                clk,
  input  logic                                rst,
  ulbp_pixel_if.sink                          pixels,
  input  logic [WCNT_W-1:0]                   width,
  input  logic [ulbp_pkg::ROW_W-1:0]          height,
  input  logic [ulbp_pkg::COUNT_W-1:0]        q_count,
  output logic                                push,
  output ulbp_pkg::desc_t                     push_desc
);

  logic [COL_W-1:0]           col;
  logic [COL_W-1:0]           col_next;
  logic [ulbp_pkg::ROW_W-1:0] row;
  logic [ulbp_pkg::ROW_W-1:0] row_next;

  logic                       accept;
  logic                       wrap_col;
  logic [ulbp_pkg::ROW_W:0]   row_pre;
  logic [ulbp_pkg::ROW_W:0]   row_inc;
  logic [ulbp_pkg::ROW_W-1:0] r0;
  logic [COL_W-1:0]           c0;
  logic [WCNT_W-1:0]          c_inc;
  logic                       end_col;
  logic                       last_col;
  logic                       last_row;
  ulbp_pkg::slot_mask_t       mask0;

  logic                            s1_valid;
  logic [ulbp_pkg::PIXEL_W-1:0]    s1_pix;
  logic [COL_W-1:0]                s1_c;
  logic                            s1_interior;
  ulbp_pkg::slot_mask_t            s1_mask;
  logic [ulbp_pkg::ROW_W-1:0]      s1_row_up;
  logic [ulbp_pkg::ROW_W-1:0]      s1_row;
  logic [ulbp_pkg::OUT_COL_W-1:0]  s1_col_left;
  logic [ulbp_pkg::OUT_COL_W-1:0]  s1_col_last;

  // Each entry holds the middle line in the high byte and the upper line in the low byte.
  logic [2*ulbp_pkg::PIXEL_W-1:0] lines [MAX_WIDTH];
  logic [2*ulbp_pkg::PIXEL_W-1:0] line_rd;
  logic [ulbp_pkg::PIXEL_W-1:0]   up;
  logic [ulbp_pkg::PIXEL_W-1:0]   mid;
  logic [ulbp_pkg::PIXEL_W-1:0]   win [6];
  logic [ulbp_pkg::PIXEL_W-1:0]   ctr;
  logic [ulbp_pkg::NEIGHBOUR_BITS-1:0] code;

  assign pixels.ready = (int'(q_count) + int'(s1_valid)) < ulbp_pkg::QUEUE_DEPTH;
  assign accept = pixels.valid && pixels.ready;

  // A pending position beyond the current geometry starts a new row or frame.
  always_comb begin
    wrap_col = WCNT_W'(col) >= width;
    c0       = wrap_col ? '0 : col;
    row_pre  = wrap_col ? (ulbp_pkg::ROW_W + 1)'(row) + 17'd1 : (ulbp_pkg::ROW_W + 1)'(row);
    r0       = (row_pre >= (ulbp_pkg::ROW_W + 1)'(height)) ? '0
                                                           : row_pre[ulbp_pkg::ROW_W-1:0];
    c_inc    = WCNT_W'(c0) + WCNT_W'(1);
    end_col  = c_inc >= width;
    row_inc  = (ulbp_pkg::ROW_W + 1)'(r0) + 17'd1;
    if (end_col) begin
      col_next = '0;
      row_next = (row_inc >= (ulbp_pkg::ROW_W + 1)'(height)) ? '0
                                                             : row_inc[ulbp_pkg::ROW_W-1:0];
    end else begin
      col_next = c_inc[COL_W-1:0];
      row_next = r0;
    end
    last_col = WCNT_W'(c0) == (width - WCNT_W'(1));
    last_row = r0 == (height - 16'd1);
    mask0 = '0;
    if (r0 != '0) begin
      mask0[0] = c0 != '0;
      mask0[1] = last_col;
      mask0[2] = last_row && (c0 != '0);
      mask0[3] = last_row && last_col;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col      <= '0;
      row      <= '0;
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
      if (accept) begin
        col <= col_next;
        row <= row_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix      <= pixels.pixel_value;
      s1_c        <= c0;
      s1_interior <= (r0 >= 16'd2) && (WCNT_W'(c0) >= WCNT_W'(2));
      s1_mask     <= mask0;
      s1_row_up   <= r0 - 16'd1;
      s1_row      <= r0;
      s1_col_left <= ulbp_pkg::OUT_COL_W'(c0 - COL_W'(1));
      s1_col_last <= ulbp_pkg::OUT_COL_W'(width - WCNT_W'(1));
    end
  end

  // Read at acceptance, write back in the following cycle once the old middle byte is known.
  always_ff @(posedge clk) begin
    if (accept) begin
      line_rd <= lines[c0];
    end
    if (s1_valid) begin
      lines[s1_c] <= {s1_pix, line_rd[2*ulbp_pkg::PIXEL_W-1:ulbp_pkg::PIXEL_W]};
    end
  end

  assign up  = line_rd[ulbp_pkg::PIXEL_W-1:0];
  assign mid = line_rd[2*ulbp_pkg::PIXEL_W-1:ulbp_pkg::PIXEL_W];
  assign ctr = win[4];

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      win[0] <= win[3];
      win[1] <= win[4];
      win[2] <= win[5];
      win[3] <= up;
      win[4] <= mid;
      win[5] <= s1_pix;
    end
  end

  always_comb begin
    code[0] = ctr < win[0];
    code[1] = ctr < win[3];
    code[2] = ctr < up;
    code[3] = ctr < win[1];
    code[4] = ctr < mid;
    code[5] = ctr < win[2];
    code[6] = ctr < win[5];
    code[7] = ctr < s1_pix;
  end

  assign push = s1_valid && (s1_mask != '0);

  always_comb begin
    push_desc.code     = code;
    push_desc.interior = s1_interior;
    push_desc.mask     = s1_mask;
    push_desc.row_up   = s1_row_up;
    push_desc.row      = s1_row;
    push_desc.col_left = s1_col_left;
    push_desc.col_last = s1_col_last;
  end

  // The write-back of one pixel must never land on the entry the next pixel reads.
  a_no_line_hazard: assert property (@(posedge clk) disable iff (rst)
    (accept && s1_valid) |-> (c0 != s1_c))
    else $error("line memory read collides with pending write-back");

endmodule

>>> sv/ulbp_queue.sv
`timescale 1ns / 1ps
// Short descriptor queue between the code generator and the result sequencer.
module ulbp_queue (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  ulbp_pkg::desc_t               push_desc,
  input  logic                          pop,
  output ulbp_pkg::desc_t               head,
  output logic [ulbp_pkg::COUNT_W-1:0]  count
);

  localparam int PTR_W = $clog2(ulbp_pkg::QUEUE_DEPTH);

  ulbp_pkg::desc_t  entries [ulbp_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] n;
    if (p == PTR_W'(ulbp_pkg::QUEUE_DEPTH - 1)) begin
      n = '0;
    end else begin
      n = p + PTR_W'(1);
    end
    return n;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      count <= count + ulbp_pkg::COUNT_W'(push) - ulbp_pkg::COUNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_desc;
    end
  end

  assign head = entries[rd_ptr];

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && !pop && (count == ulbp_pkg::COUNT_W'(ulbp_pkg::QUEUE_DEPTH))))
    else $error("descriptor queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> (count != '0))
    else $error("descriptor queue popped while empty");

endmodule

>>> sv/ulbp_back.sv
`timescale 1ns / 1ps
// Back end: looks up labels and emits the results of each queued pixel in order.
module ulbp_back (
  input  logic                          clk,
  input  logic                          rst,
  input  ulbp_pkg::desc_t               head,
  input  logic [ulbp_pkg::COUNT_W-1:0]  q_count,
  input  ulbp_pkg::class_t              lclass,
  output logic                          pop,
  ulbp_result_if.source                 results
);

  ulbp_pkg::slot_mask_t done;
  ulbp_pkg::slot_mask_t rem;
  ulbp_pkg::slot_mask_t pick;
  ulbp_pkg::slot_mask_t rem_after;
  logic                 nonempty;
  logic                 load;
  ulbp_pkg::rank_t      rank;

  logic                            res_valid;
  ulbp_pkg::label_t                res_label;
  logic [ulbp_pkg::ROW_W-1:0]      res_row;
  logic [ulbp_pkg::OUT_COL_W-1:0]  res_col;
  logic                            res_last;

  ulbp_pkg::label_t                label_next;
  logic [ulbp_pkg::ROW_W-1:0]      row_next;
  logic [ulbp_pkg::OUT_COL_W-1:0]  col_next;

  assign nonempty  = q_count != '0;
  assign rem       = head.mask & ~done;
  assign load      = nonempty && (!res_valid || results.ready);
  assign rem_after = rem & ~pick;
  assign pop       = load && (rem_after == '0);
  assign rank      = ulbp_pkg::RANK_ROM[head.code][lclass];

  always_comb begin
    if (rem[0]) begin
      pick = ulbp_pkg::SLOT_CENTER;
    end else if (rem[1]) begin
      pick = ulbp_pkg::SLOT_EDGE;
    end else if (rem[2]) begin
      pick = ulbp_pkg::SLOT_BOTTOM;
    end else if (rem[3]) begin
      pick = ulbp_pkg::SLOT_BOT_EDGE;
    end else begin
      pick = '0;
    end
  end

  always_comb begin
    case (pick)
      ulbp_pkg::SLOT_CENTER: begin
        label_next = head.interior ? $signed({1'b0, rank}) : ulbp_pkg::BORDER_LABEL;
        row_next   = head.row_up;
        col_next   = head.col_left;
      end
      ulbp_pkg::SLOT_EDGE: begin
        label_next = ulbp_pkg::BORDER_LABEL;
        row_next   = head.row_up;
        col_next   = head.col_last;
      end
      ulbp_pkg::SLOT_BOTTOM: begin
        label_next = ulbp_pkg::BORDER_LABEL;
        row_next   = head.row;
        col_next   = head.col_left;
      end
      ulbp_pkg::SLOT_BOT_EDGE: begin
        label_next = ulbp_pkg::BORDER_LABEL;
        row_next   = head.row;
        col_next   = head.col_last;
      end
      default: begin
        label_next = ulbp_pkg::BORDER_LABEL;
        row_next   = head.row_up;
        col_next   = head.col_left;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done      <= '0;
      res_valid <= 1'b0;
    end else begin
      if (load) begin
        res_valid <= 1'b1;
        done      <= pop ? '0 : (done | pick);
      end else if (results.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_label <= label_next;
      res_row   <= row_next;
      res_col   <= col_next;
      res_last  <= rem_after == '0;
    end
  end

  assign results.valid   = res_valid;
  assign results.label   = res_label;
  assign results.out_row = res_row;
  assign results.out_col = res_col;
  assign results.last    = res_last;

  a_one_slot: assert property (@(posedge clk) disable iff (rst)
    load |-> $onehot(pick))
    else $error("result slot selection is not one-hot");

  a_done_within_mask: assert property (@(posedge clk) disable iff (rst)
    nonempty |-> ((done & ~head.mask) == '0))
    else $error("completed slots outside the head pixel's result set");

  a_last_on_pop: assert property (@(posedge clk) disable iff (rst)
    load |=> (results.last == $past(pop)))
    else $error("last flag does not match the pixel's final result");

endmodule

>>> sv/uniform_lbp_3x3_labeler.sv
`timescale 1ns / 1ps
// Uniform LBP 3x3 labeler: takes one 8-bit pixel per clock in raster order and
// returns, for the pixel one row up and one column left, a label of -1 on the
// image border, 0 for a code with more transitions than uniform_limit, or the
// rank of the uniform code from 1, together with its row and column. A pixel
// passes the input register, descriptor queue and output register before its
// first result. Interior pixels give one result each and stream at one pixel per
// clock; last-column or last-row pixels give up to four results, which leave one
// per clock from the output register (given results.ready), so the input pauses
// while the four-entry queue is full. Two line buffers share one MAX_WIDTH x 16
// memory, read at acceptance and written back the next cycle; it needs no
// clearing after reset. Configuration is written through cfg_we, cfg_index and
// cfg_data only while no pixel is in flight; the user, not the block, ensures it.
module uniform_lbp_3x3_labeler #(
  parameter int MAX_WIDTH = ulbp_pkg::MAX_WIDTH
) (
  input  logic                                 clk,
  input  logic                                 rst,
  ulbp_pixel_if.sink                           pixels,
  ulbp_result_if.source                        results,
  input  logic                                 cfg_we,
  input  logic [ulbp_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [ulbp_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int WCNT_W     = $clog2(MAX_WIDTH + 1);
  localparam int WIDTH_INIT = (ulbp_pkg::IMAGE_WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH
                                                                        : ulbp_pkg::IMAGE_WIDTH_RESET;

  logic [WCNT_W-1:0]          width;
  logic [ulbp_pkg::ROW_W-1:0] height;
  ulbp_pkg::class_t           lclass;

  logic [WCNT_W-1:0]          width_clamped;
  logic [ulbp_pkg::ROW_W-1:0] height_clamped;
  int                         width_req;

  logic                                push;
  ulbp_pkg::desc_t                     push_desc;
  logic                                pop;
  ulbp_pkg::desc_t                     head;
  logic [ulbp_pkg::COUNT_W-1:0]        q_count;

  // Out-of-range geometry is clamped once, when the register is written.
  always_comb begin
    width_req = int'(cfg_data[ulbp_pkg::CFG_WIDTH_W-1:0]);
    if (width_req < ulbp_pkg::MIN_DIM) begin
      width_clamped = WCNT_W'(ulbp_pkg::MIN_DIM);
    end else if (width_req > MAX_WIDTH) begin
      width_clamped = WCNT_W'(MAX_WIDTH);
    end else begin
      width_clamped = WCNT_W'(width_req);
    end
    if (cfg_data < ulbp_pkg::CFG_DATA_W'(ulbp_pkg::MIN_DIM)) begin
      height_clamped = ulbp_pkg::ROW_W'(ulbp_pkg::MIN_DIM);
    end else begin
      height_clamped = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width  <= WCNT_W'(WIDTH_INIT);
      height <= ulbp_pkg::ROW_W'(ulbp_pkg::IMAGE_HEIGHT_RESET);
      lclass <= ulbp_pkg::limit_class(ulbp_pkg::CFG_LIMIT_W'(ulbp_pkg::LIMIT_RESET));
    end else if (cfg_we) begin
      unique case (cfg_index)
        ulbp_pkg::REG_IMAGE_WIDTH:   width  <= width_clamped;
        ulbp_pkg::REG_IMAGE_HEIGHT:  height <= height_clamped;
        ulbp_pkg::REG_UNIFORM_LIMIT: begin
          lclass <= ulbp_pkg::limit_class(cfg_data[ulbp_pkg::CFG_LIMIT_W-1:0]);
        end
        default: ;
      endcase
    end
  end

  ulbp_front #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .pixels    (pixels),
    .width     (width),
    .height    (height),
    .q_count   (q_count),
    .push      (push),
    .push_desc (push_desc)
  );

  ulbp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .head      (head),
    .count     (q_count)
  );

  ulbp_back u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (head),
    .q_count (q_count),
    .lclass  (lclass),
    .pop     (pop),
    .results (results)
  );

endmodule
